### rtl/tatp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package tatp_pkg;

    typedef enum logic [1:0] {
        KIND_STATE   = 2'd0,
        KIND_PROFILE = 2'd1,
        KIND_PICK    = 2'd2,
        KIND_NONE    = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        TS_UNUSED  = 2'd0,
        TS_READY   = 2'd1,
        TS_RUNNING = 2'd2,
        TS_BLOCKED = 2'd3
    } task_state_t;

    typedef enum logic [1:0] {
        MODE_RR      = 2'd0,
        MODE_AGING   = 2'd1,
        MODE_PRIO    = 2'd2,
        MODE_PRIO_B  = 2'd3
    } sched_mode_t;

    typedef enum logic [1:0] {
        INT_PERF    = 2'd0,
        INT_EFF     = 2'd1,
        INT_LATENCY = 2'd2,
        INT_DEFAULT = 2'd3
    } intent_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_AGE,
        ST_FINISH
    } fsm_t;

    localparam logic [2:0] REG_SCHED_MODE    = 3'd0;
    localparam logic [2:0] REG_PCORE_MAP     = 3'd1;
    localparam logic [2:0] REG_CPU_NODE_MAP  = 3'd2;
    localparam logic [2:0] REG_AGING_THRESH  = 3'd3;
    localparam logic [2:0] REG_AGING_BOOST   = 3'd4;
    localparam logic [2:0] REG_LATENCY_BOOST = 3'd5;

    localparam int          CFG_W        = 16;
    localparam int          PRIO_W       = 8;
    localparam logic [7:0]  LOCAL_BONUS  = 8'd5;
    localparam logic [15:0] WAIT_MAX     = 16'hFFFF;

endpackage
`default_nettype wire

### rtl/topology_aware_task_picker_unit.sv
// Topology-aware task picker. A start is accepted when start is high and busy
// is low; the block then holds busy until its single result strobes on done for
// exactly one cycle, and the receiver cannot stall it. Kinds 0 and 1 (state
// write, profile set) and ignored kinds go straight to the finish step. A
// priority pick walks the task table one slot per cycle through one shared
// priority adder and comparator; in aging mode, when an eligible slot was
// found, a second walk through the same slot port updates the wait counts.
// A round-robin pick stops at the first runnable slot it reaches. The task
// table sits in per-slot registers that reset clears, so no clearing pass
// is needed after reset. Configuration writes are taken at any edge with
// cfg_we high and must only happen while the block is idle.
`timescale 1ns / 1ps
`default_nettype none
module topology_aware_task_picker_unit
    import tatp_pkg::*;
#(
    parameter int TASK_SLOTS = 32,
    parameter int CPU_COUNT  = 4
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    output logic                      busy,
    output logic                      done,
    input  wire logic                 cfg_we,
    input  wire logic [2:0]           cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data,
    input  wire logic [1:0]           kind,
    input  wire logic [4:0]           slot,
    input  wire logic [1:0]           task_state,
    input  wire logic [1:0]           intent,
    input  wire logic                 region_valid,
    input  wire logic                 data_node,
    input  wire logic [4:0]           current_slot,
    input  wire logic                 current_valid,
    output logic [4:0]                chosen_slot,
    output logic                      found,
    output logic                      switched,
    output logic [1:0]                cpu_used,
    output logic [3:0]                affinity_out
);

    localparam int SW = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
    localparam int CW = (CPU_COUNT > 1) ? $clog2(CPU_COUNT) : 1;
    localparam int AW = (CPU_COUNT > 4) ? CPU_COUNT : 4;

    // Configuration registers.
    logic [1:0]  sched_mode_reg;
    logic [3:0]  pcore_map_reg;
    logic [3:0]  cpu_node_map_reg;
    logic [15:0] aging_threshold_reg;
    logic [5:0]  aging_boost_value_reg;
    logic [5:0]  latency_boost_value_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sched_mode_reg          <= 2'd0;
            pcore_map_reg           <= 4'd3;
            cpu_node_map_reg        <= 4'd12;
            aging_threshold_reg     <= 16'd10;
            aging_boost_value_reg   <= 6'd10;
            latency_boost_value_reg <= 6'd10;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_SCHED_MODE:    sched_mode_reg          <= cfg_data[1:0];
                REG_PCORE_MAP:     pcore_map_reg           <= cfg_data[3:0];
                REG_CPU_NODE_MAP:  cpu_node_map_reg        <= cfg_data[3:0];
                REG_AGING_THRESH:  aging_threshold_reg     <= cfg_data[15:0];
                REG_AGING_BOOST:   aging_boost_value_reg   <= cfg_data[5:0];
                REG_LATENCY_BOOST: latency_boost_value_reg <= cfg_data[5:0];
                default:           ;
            endcase
        end
    end

    // Task table, one register set per slot.
    logic [1:0]          st_reg   [TASK_SLOTS];
    logic                prof_reg [TASK_SLOTS];
    logic [CPU_COUNT-1:0] aff_reg [TASK_SLOTS];
    logic [5:0]          ib_reg   [TASK_SLOTS];
    logic [5:0]          ab_reg   [TASK_SLOTS];
    logic                pn_reg   [TASK_SLOTS];
    logic [15:0]         wc_reg   [TASK_SLOTS];

    // Latched item and sequencer state.
    fsm_t            state_reg, state_next;
    logic [1:0]      kind_reg;
    logic [4:0]      slot_in_reg;
    logic [1:0]      tstate_reg;
    logic [1:0]      intent_reg;
    logic            rv_reg;
    logic            node_reg;
    logic [4:0]      cur_in_reg;
    logic            cur_ok_reg;
    logic [SW:0]     idx_reg;
    logic [SW:0]     n_reg;
    logic            best_v_reg;
    logic [SW-1:0]   best_reg;
    logic [PRIO_W-1:0] bestp_reg;
    logic            cand_reg;
    logic [SW-1:0]   start_pt_reg;
    logic [SW-1:0]   cursor_reg;
    logic            cursor_v_reg;
    logic [CW-1:0]   cpu_reg;

    logic            accept;
    assign accept = start && (state_reg == ST_IDLE);
    assign busy   = (state_reg != ST_IDLE);

    // Mask and node helpers.
    logic [AW-1:0] all_mask;
    logic [AW-1:0] pmask;
    logic [AW-1:0] imask;
    logic [AW-1:0] nmask;
    logic [AW-1:0] amask;
    logic          cpu_node;

    always_comb
    begin
        all_mask = '0;
        all_mask[CPU_COUNT-1:0] = '1;
        pmask = all_mask & {{(AW-4){1'b0}}, pcore_map_reg};
        case (intent_t'(intent_reg))
            INT_PERF, INT_LATENCY: imask = pmask;
            INT_EFF:               imask = all_mask & ~pmask;
            default:               imask = all_mask;
        endcase
        nmask = '0;
        for (int c = 0; c < CPU_COUNT; c++)
        begin
            if (((c < 4) ? cpu_node_map_reg[c[1:0]] : 1'b0) == node_reg)
                nmask[c] = 1'b1;
        end
        amask = imask;
        if (rv_reg)
        begin
            amask = imask & nmask;
            if (amask == '0)
                amask = imask;
        end
        cpu_node = (32'(cpu_reg) < 4) ? cpu_node_map_reg[2'(cpu_reg)] : 1'b0;
    end

    // Shared scan unit: one slot evaluated per cycle.
    logic [SW-1:0]     sidx;
    logic              s_run;
    logic              s_elig;
    logic [PRIO_W-1:0] s_prio;
    logic [SW:0]       rr_sum;

    always_comb
    begin
        rr_sum = {1'b0, start_pt_reg} + n_reg;
        if (sched_mode_reg == MODE_RR)
            sidx = (rr_sum >= (SW+1)'(TASK_SLOTS)) ?
                   SW'(rr_sum - (SW+1)'(TASK_SLOTS)) : rr_sum[SW-1:0];
        else
            sidx = idx_reg[SW-1:0];
        s_run  = (st_reg[sidx] == TS_READY) || (st_reg[sidx] == TS_RUNNING);
        s_elig = s_run && (!prof_reg[sidx] || aff_reg[sidx][cpu_reg]);
        s_prio = '0;
        if (prof_reg[sidx])
            s_prio = PRIO_W'(ib_reg[sidx]) + PRIO_W'(ab_reg[sidx]) +
                     ((pn_reg[sidx] == cpu_node) ? LOCAL_BONUS : '0);
    end

    logic        slot_ok;
    logic        cur_in_range;
    assign slot_ok      = (32'(slot_in_reg) < TASK_SLOTS);
    assign cur_in_range = (32'(current_slot) < TASK_SLOTS);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (start)
                    state_next = (kind_t'(kind) == KIND_PICK) ? ST_SCAN : ST_FINISH;
            ST_SCAN:
                if (sched_mode_reg == MODE_RR)
                begin
                    if ((!(cand_reg && sidx == SW'(cur_in_reg)) && s_run) ||
                        (n_reg == (SW+1)'(TASK_SLOTS-1)))
                        state_next = ST_FINISH;
                end
                else if (idx_reg == (SW+1)'(TASK_SLOTS-1))
                    state_next = (sched_mode_reg == MODE_AGING) &&
                                 (best_v_reg || s_elig) ? ST_AGE : ST_FINISH;
            ST_AGE:
                if (idx_reg == (SW+1)'(TASK_SLOTS-1))
                    state_next = ST_FINISH;
            ST_FINISH:
                state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    logic rr_hit;
    assign rr_hit = !(cand_reg && sidx == SW'(cur_in_reg)) && s_run;

    logic          pick_v;
    logic [SW-1:0] pick;
    always_comb
    begin
        pick_v = best_v_reg;
        pick   = best_reg;
        if (sched_mode_reg == MODE_RR && !best_v_reg && cand_reg)
        begin
            pick_v = 1'b1;
            pick   = SW'(cur_in_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // Datapath and table updates.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < TASK_SLOTS; i++)
            begin
                st_reg[i]   <= TS_UNUSED;
                prof_reg[i] <= 1'b0;
                aff_reg[i]  <= '0;
                ib_reg[i]   <= '0;
                ab_reg[i]   <= '0;
                pn_reg[i]   <= 1'b0;
                wc_reg[i]   <= '0;
            end
            cursor_reg   <= '0;
            cursor_v_reg <= 1'b0;
            cpu_reg      <= '0;
            done         <= 1'b0;
            chosen_slot  <= '0;
            found        <= 1'b0;
            switched     <= 1'b0;
            cpu_used     <= '0;
            affinity_out <= '0;
            kind_reg     <= '0;
            slot_in_reg  <= '0;
            tstate_reg   <= '0;
            intent_reg   <= '0;
            rv_reg       <= 1'b0;
            node_reg     <= 1'b0;
            cur_in_reg   <= '0;
            cur_ok_reg   <= 1'b0;
            idx_reg      <= '0;
            n_reg        <= '0;
            best_v_reg   <= 1'b0;
            best_reg     <= '0;
            bestp_reg    <= '0;
            cand_reg     <= 1'b0;
            start_pt_reg <= '0;
        end
        else
        begin
            done <= 1'b0;
            case (state_reg)
                ST_IDLE:
                    if (accept)
                    begin
                        kind_reg    <= kind;
                        slot_in_reg <= slot;
                        tstate_reg  <= task_state;
                        intent_reg  <= intent;
                        rv_reg      <= region_valid;
                        node_reg    <= data_node;
                        cur_in_reg  <= current_slot;
                        cur_ok_reg  <= current_valid && cur_in_range;
                        idx_reg     <= '0;
                        n_reg       <= '0;
                        best_v_reg  <= 1'b0;
                        best_reg    <= '0;
                        bestp_reg   <= '0;
                        cand_reg    <= current_valid && cur_in_range &&
                            ((st_reg[SW'(current_slot)] == TS_READY) ||
                             (st_reg[SW'(current_slot)] == TS_RUNNING));
                        if (kind_t'(kind) == KIND_PICK && sched_mode_reg == MODE_RR)
                        begin
                            if (current_valid && cur_in_range)
                            begin
                                cursor_reg   <= SW'(current_slot);
                                cursor_v_reg <= 1'b1;
                                start_pt_reg <= (32'(current_slot) == TASK_SLOTS-1) ?
                                                '0 : SW'(current_slot) + 1'b1;
                            end
                            else if (cursor_v_reg)
                                start_pt_reg <= (32'(cursor_reg) == TASK_SLOTS-1) ?
                                                '0 : cursor_reg + 1'b1;
                            else
                                start_pt_reg <= '0;
                        end
                    end
                ST_SCAN:
                    if (sched_mode_reg == MODE_RR)
                    begin
                        n_reg <= n_reg + 1'b1;
                        if (rr_hit)
                        begin
                            best_v_reg <= 1'b1;
                            best_reg   <= sidx;
                        end
                    end
                    else
                    begin
                        if (s_elig && (!best_v_reg || s_prio > bestp_reg))
                        begin
                            best_v_reg <= 1'b1;
                            best_reg   <= sidx;
                            bestp_reg  <= s_prio;
                        end
                        idx_reg <= (idx_reg == (SW+1)'(TASK_SLOTS-1)) ? '0 : idx_reg + 1'b1;
                    end
                ST_AGE:
                begin
                    // Age every other ready, profiled slot; saturate wait count.
                    if (st_reg[sidx] == TS_READY && sidx != best_reg && prof_reg[sidx])
                    begin
                        if (wc_reg[sidx] != WAIT_MAX)
                        begin
                            wc_reg[sidx] <= wc_reg[sidx] + 1'b1;
                            if ((wc_reg[sidx] + 1'b1) > aging_threshold_reg)
                                ab_reg[sidx] <= aging_boost_value_reg;
                        end
                        else if (wc_reg[sidx] > aging_threshold_reg)
                            ab_reg[sidx] <= aging_boost_value_reg;
                    end
                    idx_reg <= idx_reg + 1'b1;
                end
                ST_FINISH:
                begin
                    done         <= 1'b1;
                    chosen_slot  <= '0;
                    found        <= 1'b0;
                    switched     <= 1'b0;
                    cpu_used     <= '0;
                    affinity_out <= '0;
                    case (kind_t'(kind_reg))
                        KIND_STATE:
                            if (slot_ok)
                                st_reg[SW'(slot_in_reg)] <= tstate_reg;
                        KIND_PROFILE:
                        begin
                            affinity_out <= amask[3:0];
                            if (slot_ok)
                            begin
                                if (!prof_reg[SW'(slot_in_reg)])
                                begin
                                    wc_reg[SW'(slot_in_reg)] <= '0;
                                    ab_reg[SW'(slot_in_reg)] <= '0;
                                end
                                prof_reg[SW'(slot_in_reg)] <= 1'b1;
                                aff_reg[SW'(slot_in_reg)]  <= amask[CPU_COUNT-1:0];
                                ib_reg[SW'(slot_in_reg)]   <=
                                    (intent_t'(intent_reg) == INT_LATENCY) ?
                                    latency_boost_value_reg : '0;
                                pn_reg[SW'(slot_in_reg)]   <= rv_reg & node_reg;
                            end
                        end
                        KIND_PICK:
                        begin
                            cpu_used <= 2'(cpu_reg);
                            if (sched_mode_reg == MODE_RR)
                            begin
                                if (best_v_reg)
                                begin
                                    cursor_reg   <= best_reg;
                                    cursor_v_reg <= 1'b1;
                                end
                                else if (!cand_reg)
                                    cursor_v_reg <= 1'b0;
                            end
                            if (!pick_v)
                                chosen_slot <= cur_ok_reg ? cur_in_reg : '0;
                            else
                            begin
                                chosen_slot <= 5'(pick);
                                found       <= 1'b1;
                                if (!cur_ok_reg || pick != SW'(cur_in_reg))
                                begin
                                    switched <= 1'b1;
                                    if (prof_reg[pick])
                                    begin
                                        wc_reg[pick] <= '0;
                                        ab_reg[pick] <= '0;
                                    end
                                    cpu_reg <= (32'(cpu_reg) == CPU_COUNT-1) ?
                                               '0 : cpu_reg + 1'b1;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
                default: ;
            endcase
        end
    end

    // A result is only produced from the finish step.
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg) == ST_FINISH)
        else $error("done without finish step");

    // busy stays high while an item is in flight, so no new item is accepted.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> busy)
        else $error("busy low during work");

    // switched implies found.
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && switched) |-> found)
        else $error("switch without a found task");

    // The CPU index only moves on a finishing pick.
    assert property (@(posedge clk) disable iff (!rst_n)
        (cpu_reg != $past(cpu_reg)) |-> (done && switched))
        else $error("cpu index moved outside a switch");

endmodule
`default_nettype wire
